FILE: hw/rtl/bip_pkg.sv
// ----------------------------------------------------------------------------
// bip_pkg
// Shared constants, codes and controller/datapath interface types for the
// polar-grid bilinear interpolator.
// ----------------------------------------------------------------------------
package bip_pkg;

  localparam int MAX_RADIUS_POINTS_DEF = 64;
  localparam int MAX_ANGLE_POINTS_DEF  = 64;
  localparam int COMPONENTS_DEF        = 3;

  // load data is sign-extended from this many bits
  localparam int VALUE_BITS = 32;
  localparam int LOAD_BITS  = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  localparam int COORD_W  = 32;
  localparam int WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] ONE_W = 17'h10000;

  localparam logic [1:0] OP_LOAD_RADIUS = 2'd0;
  localparam logic [1:0] OP_LOAD_ANGLE  = 2'd1;
  localparam logic [1:0] OP_LOAD_GRID   = 2'd2;
  localparam logic [1:0] OP_QUERY       = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_RANGE      = 2'd1;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;

  localparam logic [1:0] CFG_RADIUS_POINTS = 2'd0;
  localparam logic [1:0] CFG_ANGLE_POINTS  = 2'd1;
  localparam logic [1:0] CFG_RANGE_TOL     = 2'd2;

  // breakpoint table read select
  localparam logic [2:0] TRD_NONE  = 3'd0;
  localparam logic [2:0] TRD_FIRST = 3'd1;
  localparam logic [2:0] TRD_LAST  = 3'd2;
  localparam logic [2:0] TRD_PROBE = 3'd3;
  localparam logic [2:0] TRD_LO    = 3'd4;
  localparam logic [2:0] TRD_HI    = 3'd5;

  // cell corners: radius side, angle side
  localparam logic [1:0] CORNER_LL = 2'd0;
  localparam logic [1:0] CORNER_LH = 2'd1;
  localparam logic [1:0] CORNER_HL = 2'd2;
  localparam logic [1:0] CORNER_HH = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       wr_load;
    logic [2:0] trd;
    logic       cap_first;
    logic       cap_last;
    logic       srch_init;
    logic       srch_step;
    logic       cell_set;
    logic       addr_row;
    logic       cap_lo;
    logic       addr_base;
    logic       cap_hi;
    logic       div_start;
    logic       acc_clr;
    logic       g_issue;
    logic       g_mul;
    logic       g_acc;
    logic [1:0] corner;
    logic       finish;
    logic [1:0] fin_status;
  } bip_cmd_t;

  typedef struct packed {
    logic is_query;
    logic range_ok;
    logic search_done;
    logic diff_ok;
    logic div_done;
  } bip_stat_t;

endpackage

FILE: hw/rtl/bip_ram.sv
// ----------------------------------------------------------------------------
// bip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bip_div.sv
// ----------------------------------------------------------------------------
// bip_div
// Restoring divider for one Q1.16 interpolation weight, one quotient bit
// per cycle. Saturates to 0 and to 1.0 outside the interval.
// ----------------------------------------------------------------------------
module bip_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [bip_pkg::COORD_W:0] num,
  input  logic signed [bip_pkg::COORD_W:0] den,
  output logic                           done,
  output logic [bip_pkg::WEIGHT_W-1:0]   weight
);
  import bip_pkg::*;

  localparam int DW     = COORD_W + 1;
  localparam int QSTEPS = WEIGHT_W - 1;
  localparam int CW     = $clog2(QSTEPS + 1);

  logic          run_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [WEIGHT_W-1:0] quo_r;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= (num > 0) && (num < den);
    end else if (run_r && cnt_r == CW'(1)) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(QSTEPS);
      rem_r <= DW'(num);
      den_r <= DW'(den);
      if (num <= 0) begin
        quo_r <= '0;
      end else if (num >= den) begin
        quo_r <= ONE_W;
      end else begin
        quo_r <= '0;
      end
    end else if (run_r) begin
      cnt_r <= cnt_r - CW'(1);
      rem_r <= fits ? DW'(shifted - {1'b0, den_r}) : DW'(shifted);
      quo_r <= {quo_r[WEIGHT_W-2:0], fits};
    end
  end

  assign done   = !run_r;
  assign weight = quo_r;

endmodule

FILE: hw/rtl/bip_dp.sv
// ----------------------------------------------------------------------------
// bip_dp
// Datapath: breakpoint and grid memories, bound checks, lower-bound search
// registers, weight dividers, corner multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module bip_dp #(
  parameter int MAX_RADIUS_POINTS = bip_pkg::MAX_RADIUS_POINTS_DEF,
  parameter int MAX_ANGLE_POINTS  = bip_pkg::MAX_ANGLE_POINTS_DEF,
  parameter int COMPONENTS        = bip_pkg::COMPONENTS_DEF,
  localparam int NRW = $clog2(MAX_RADIUS_POINTS + 1),
  localparam int NAW = $clog2(MAX_ANGLE_POINTS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          in_op,
  input  logic [11:0]                         in_entry_index,
  input  logic [1:0]                          in_component,
  input  logic signed [bip_pkg::COORD_W-1:0]  in_load_data,
  input  logic signed [bip_pkg::COORD_W-1:0]  in_coord_radius,
  input  logic signed [bip_pkg::COORD_W-1:0]  in_coord_angle,
  input  logic [NRW-1:0]                      radius_points,
  input  logic [NAW-1:0]                      angle_points,
  input  logic [15:0]                         range_tolerance,
  input  bip_pkg::bip_cmd_t                   cmd,
  output bip_pkg::bip_stat_t                  stat,
  output logic                                out_valid,
  output logic signed [bip_pkg::COORD_W-1:0]  out_interp_value,
  output logic [1:0]                          out_status
);
  import bip_pkg::*;

  localparam int RAW    = (MAX_RADIUS_POINTS > 1) ? $clog2(MAX_RADIUS_POINTS) : 1;
  localparam int AAW    = (MAX_ANGLE_POINTS > 1) ? $clog2(MAX_ANGLE_POINTS) : 1;
  localparam int NODES  = MAX_RADIUS_POINTS * MAX_ANGLE_POINTS;
  localparam int GDEPTH = NODES * COMPONENTS;
  localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int ROWW   = RAW + NAW;
  localparam int STRW   = NAW + 2;
  localparam int SH     = COORD_W - LOAD_BITS;
  localparam int PW     = 2 * COORD_W + 2;

  // latched item
  logic [1:0]  op_r;
  logic [11:0] idx_r;
  logic [1:0]  comp_r;
  logic signed [COORD_W-1:0] ldata_r, r_r, a_r;

  // breakpoint values
  logic signed [COORD_W-1:0] rtab0_r, rtabn_r, atab0_r, atabn_r, rlo_r, alo_r;
  logic signed [COORD_W:0]   dr_r, da_r, rnum_r, anum_r;

  // search and cell
  logic [NRW-1:0] rpos_r, rcnt_r, rprobe, rcell;
  logic [NAW-1:0] apos_r, acnt_r, aprobe, acell;
  logic [RAW-1:0] ir_r;
  logic [AAW-1:0] ia_r;

  // grid addressing and blend
  logic [ROWW-1:0] row_r;
  logic [STRW-1:0] stride_r;
  logic [GAW-1:0]  base_r;
  logic [1:0]      corner_q;
  logic [32:0]     wcorner_r;
  logic signed [PW-1:0] prod_r, acc_r, rsum;
  logic [WEIGHT_W-1:0]  wr, wa, wr_inv, wa_inv;
  logic            wr_done, wa_done;

  // result
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_value_r;
  logic [1:0]                out_status_r;

  // memory ports
  logic                      r_we, a_we, g_we;
  logic [RAW-1:0]            r_raddr;
  logic [AAW-1:0]            a_raddr;
  logic [GAW-1:0]            g_waddr, g_raddr;
  logic [COORD_W-1:0]        r_rdata_u, a_rdata_u, g_rdata_u;
  logic signed [COORD_W-1:0] r_rdata, a_rdata, g_rdata;
  logic signed [COORD_W-1:0] ldata_sh, ldata_ext;
  logic signed [COORD_W+1:0] tol_s;

  assign r_rdata = r_rdata_u;
  assign a_rdata = a_rdata_u;
  assign g_rdata = g_rdata_u;

  assign ldata_sh  = ldata_r <<< SH;
  assign ldata_ext = ldata_sh >>> SH;

  assign r_we = cmd.wr_load && op_r == OP_LOAD_RADIUS && int'(idx_r) < MAX_RADIUS_POINTS;
  assign a_we = cmd.wr_load && op_r == OP_LOAD_ANGLE && int'(idx_r) < MAX_ANGLE_POINTS;
  assign g_we = cmd.wr_load && op_r == OP_LOAD_GRID && int'(idx_r) < NODES &&
                int'(comp_r) < COMPONENTS;
  assign g_waddr = GAW'(int'(idx_r) * COMPONENTS + int'(comp_r));

  assign rprobe = rpos_r + (rcnt_r >> 1);
  assign aprobe = apos_r + (acnt_r >> 1);

  always_comb begin
    case (cmd.trd)
      TRD_FIRST: begin
        r_raddr = '0;
        a_raddr = '0;
      end
      TRD_LAST: begin
        r_raddr = RAW'(radius_points - NRW'(1));
        a_raddr = AAW'(angle_points - NAW'(1));
      end
      TRD_PROBE: begin
        r_raddr = RAW'(rprobe);
        a_raddr = AAW'(aprobe);
      end
      TRD_LO: begin
        r_raddr = ir_r - RAW'(1);
        a_raddr = ia_r - AAW'(1);
      end
      TRD_HI: begin
        r_raddr = ir_r;
        a_raddr = ia_r;
      end
      default: begin
        r_raddr = '0;
        a_raddr = '0;
      end
    endcase
  end

  // force the lower bound into 1..n-1
  always_comb begin
    rcell = (rpos_r >= radius_points) ? radius_points - NRW'(1) : rpos_r;
    if (rcell == '0) begin
      rcell = NRW'(1);
    end
    acell = (apos_r >= angle_points) ? angle_points - NAW'(1) : apos_r;
    if (acell == '0) begin
      acell = NAW'(1);
    end
  end

  assign corner_q = cmd.corner;
  always_comb begin
    case (corner_q)
      CORNER_LL: g_raddr = base_r;
      CORNER_LH: g_raddr = GAW'(int'(base_r) + COMPONENTS);
      CORNER_HL: g_raddr = GAW'(int'(base_r) + int'(stride_r));
      CORNER_HH: g_raddr = GAW'(int'(base_r) + int'(stride_r) + COMPONENTS);
      default:   g_raddr = base_r;
    endcase
  end

  assign wr_inv = ONE_W - wr;
  assign wa_inv = ONE_W - wa;
  assign tol_s  = $signed({18'b0, range_tolerance});

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_op;
      idx_r   <= in_entry_index;
      comp_r  <= in_component;
      ldata_r <= in_load_data;
      r_r     <= in_coord_radius;
      a_r     <= in_coord_angle;
    end else if (cmd.cap_last && r_r > r_rdata) begin
      r_r <= r_rdata;   // clamp radius to the last breakpoint
    end
    if (cmd.cap_first) begin
      rtab0_r <= r_rdata;
      atab0_r <= a_rdata;
    end
    if (cmd.cap_last) begin
      rtabn_r <= r_rdata;
      atabn_r <= a_rdata;
    end
    if (cmd.srch_init) begin
      rpos_r <= '0;
      rcnt_r <= radius_points;
      apos_r <= '0;
      acnt_r <= angle_points;
    end else if (cmd.srch_step) begin
      if (rcnt_r != '0) begin
        if (r_rdata < r_r) begin
          rpos_r <= rprobe + NRW'(1);
          rcnt_r <= rcnt_r - (rcnt_r >> 1) - NRW'(1);
        end else begin
          rcnt_r <= rcnt_r >> 1;
        end
      end
      if (acnt_r != '0) begin
        if (a_rdata < a_r) begin
          apos_r <= aprobe + NAW'(1);
          acnt_r <= acnt_r - (acnt_r >> 1) - NAW'(1);
        end else begin
          acnt_r <= acnt_r >> 1;
        end
      end
    end
    if (cmd.cell_set) begin
      ir_r <= RAW'(rcell);
      ia_r <= AAW'(acell);
    end
    if (cmd.addr_row) begin
      row_r    <= ROWW'((int'(ir_r) - 1) * int'(angle_points));
      stride_r <= STRW'(int'(angle_points) * COMPONENTS);
    end
    if (cmd.cap_lo) begin
      rlo_r <= r_rdata;
      alo_r <= a_rdata;
    end
    if (cmd.addr_base) begin
      base_r <= GAW'((int'(row_r) + int'(ia_r) - 1) * COMPONENTS + int'(comp_r));
    end
    if (cmd.cap_hi) begin
      dr_r   <= (COORD_W+1)'(r_rdata) - (COORD_W+1)'(rlo_r);
      da_r   <= (COORD_W+1)'(a_rdata) - (COORD_W+1)'(alo_r);
      rnum_r <= (COORD_W+1)'(r_r) - (COORD_W+1)'(rlo_r);
      anum_r <= (COORD_W+1)'(a_r) - (COORD_W+1)'(alo_r);
    end
    if (cmd.g_issue) begin
      case (corner_q)
        CORNER_LL: wcorner_r <= 33'(wr_inv * wa_inv);
        CORNER_LH: wcorner_r <= 33'(wr_inv * wa);
        CORNER_HL: wcorner_r <= 33'(wr * wa_inv);
        CORNER_HH: wcorner_r <= 33'(wr * wa);
        default:   wcorner_r <= '0;
      endcase
    end
    if (cmd.g_mul) begin
      prod_r <= g_rdata * $signed({1'b0, wcorner_r});
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.g_acc) begin
      acc_r <= acc_r + prod_r;
    end
  end

  // round Q16.48 to nearest Q16.16, ties up
  assign rsum = acc_r + (PW'(1) <<< 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= cmd.fin_status;
      out_value_r  <= (cmd.fin_status == ST_OK && op_r == OP_QUERY) ?
                      rsum[2*COORD_W-1:COORD_W] : '0;
    end
  end

  assign stat.is_query    = op_r == OP_QUERY;
  assign stat.range_ok    = int'(comp_r) < COMPONENTS &&
                            (COORD_W+2)'(r_r) >= (COORD_W+2)'(rtab0_r) - tol_s &&
                            (COORD_W+2)'(r_r) <= (COORD_W+2)'(rtabn_r) + tol_s &&
                            (COORD_W+2)'(a_r) >= (COORD_W+2)'(atab0_r) - tol_s &&
                            (COORD_W+2)'(a_r) <= (COORD_W+2)'(atabn_r) + tol_s;
  assign stat.search_done = rcnt_r == '0 && acnt_r == '0;
  assign stat.diff_ok     = dr_r > 0 && da_r > 0;
  assign stat.div_done    = wr_done && wa_done;

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_status       = out_status_r;

  bip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_RADIUS_POINTS)) u_radius_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (idx_r[RAW-1:0]),
    .wdata (ldata_ext),
    .raddr (r_raddr),
    .rdata (r_rdata_u)
  );

  bip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_ANGLE_POINTS)) u_angle_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (idx_r[AAW-1:0]),
    .wdata (ldata_ext),
    .raddr (a_raddr),
    .rdata (a_rdata_u)
  );

  bip_ram #(.WIDTH(COORD_W), .DEPTH(GDEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (ldata_ext),
    .raddr (g_raddr),
    .rdata (g_rdata_u)
  );

  bip_div u_div_radius (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num    (rnum_r),
    .den    (dr_r),
    .done   (wr_done),
    .weight (wr)
  );

  bip_div u_div_angle (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num    (anum_r),
    .den    (da_r),
    .done   (wa_done),
    .weight (wa)
  );

endmodule

FILE: hw/rtl/bip_ctrl.sv
// ----------------------------------------------------------------------------
// bip_ctrl
// Sequencer: writes a load item, or steps a query item through bound reads,
// range check, search, cell reads, weight division and the four-corner blend.
// ----------------------------------------------------------------------------
module bip_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bip_pkg::bip_stat_t stat,
  output logic               busy,
  output bip_pkg::bip_cmd_t  cmd
);
  import bip_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_RD_LAST  = 5'd2;
  localparam logic [4:0] S_CAP_LAST = 5'd3;
  localparam logic [4:0] S_RANGE    = 5'd4;
  localparam logic [4:0] S_PROBE    = 5'd5;
  localparam logic [4:0] S_STEP     = 5'd6;
  localparam logic [4:0] S_CELL     = 5'd7;
  localparam logic [4:0] S_RD_LO    = 5'd8;
  localparam logic [4:0] S_RD_HI    = 5'd9;
  localparam logic [4:0] S_CAP_HI   = 5'd10;
  localparam logic [4:0] S_EVAL     = 5'd11;
  localparam logic [4:0] S_DIV      = 5'd12;
  localparam logic [4:0] S_G_RD     = 5'd13;
  localparam logic [4:0] S_G_MUL    = 5'd14;
  localparam logic [4:0] S_G_ACC    = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic [1:0] corner_r, corner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= CORNER_LL;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.trd        = TRD_NONE;
    cmd.corner     = corner_r;
    cmd.fin_status = ST_OK;
    state_nxt      = state_r;
    corner_nxt     = corner_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_query) begin
          cmd.wr_load = 1'b1;
          cmd.finish  = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.trd   = TRD_FIRST;
          state_nxt = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        cmd.trd       = TRD_LAST;
        cmd.cap_first = 1'b1;
        state_nxt     = S_CAP_LAST;
      end
      S_CAP_LAST: begin
        cmd.cap_last = 1'b1;
        state_nxt    = S_RANGE;
      end
      S_RANGE: begin
        if (!stat.range_ok) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_RANGE;
          state_nxt      = S_IDLE;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.search_done) begin
          state_nxt = S_CELL;
        end else begin
          cmd.trd   = TRD_PROBE;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = S_PROBE;
      end
      S_CELL: begin
        cmd.cell_set = 1'b1;
        state_nxt    = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.trd      = TRD_LO;
        cmd.addr_row = 1'b1;
        state_nxt    = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.trd       = TRD_HI;
        cmd.cap_lo    = 1'b1;
        cmd.addr_base = 1'b1;
        state_nxt     = S_CAP_HI;
      end
      S_CAP_HI: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.diff_ok) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_ZERO_WIDTH;
          state_nxt      = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.acc_clr   = 1'b1;
          corner_nxt    = CORNER_LL;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_G_RD;
        end
      end
      S_G_RD: begin
        cmd.g_issue = 1'b1;
        state_nxt   = S_G_MUL;
      end
      S_G_MUL: begin
        cmd.g_mul = 1'b1;
        state_nxt = S_G_ACC;
      end
      S_G_ACC: begin
        cmd.g_acc = 1'b1;
        if (corner_r == CORNER_HH) begin
          state_nxt = S_FIN;
        end else begin
          corner_nxt = corner_r + 2'd1;
          state_nxt  = S_G_RD;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

FILE: hw/rtl/bilinear_interp_polar_grid.sv
// ----------------------------------------------------------------------------
// bilinear_interp_polar_grid
// Bilinear interpolation of a vector grid over sorted radius and angle
// breakpoint tables, Q16.16 values and Q1.16 weights.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; one item is in work
// at a time. Its result appears on out_interp_value and out_status for one
// cycle with out_valid high and cannot be held off, so the receiver must take
// it then. The two binary searches run side by side, one on each table's
// single read port, and the two weight dividers produce one quotient bit a
// cycle. Queries that fail the range or interval check finish early. Memories
// are not cleared at reset: every breakpoint and grid entry a query touches
// must have been loaded first. Configuration writes are always accepted and
// must come only while idle.
// ----------------------------------------------------------------------------
module bilinear_interp_polar_grid #(
  parameter int MAX_RADIUS_POINTS = bip_pkg::MAX_RADIUS_POINTS_DEF,
  parameter int MAX_ANGLE_POINTS  = bip_pkg::MAX_ANGLE_POINTS_DEF,
  parameter int COMPONENTS        = bip_pkg::COMPONENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic [11:0]                        in_entry_index,
  input  logic [1:0]                         in_component,
  input  logic signed [bip_pkg::COORD_W-1:0] in_load_data,
  input  logic signed [bip_pkg::COORD_W-1:0] in_coord_radius,
  input  logic signed [bip_pkg::COORD_W-1:0] in_coord_angle,
  output logic                               out_valid,
  output logic signed [bip_pkg::COORD_W-1:0] out_interp_value,
  output logic [1:0]                         out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data
);
  import bip_pkg::*;

  localparam int NRW = $clog2(MAX_RADIUS_POINTS + 1);
  localparam int NAW = $clog2(MAX_ANGLE_POINTS + 1);
  localparam int NR_RESET = (64 < MAX_RADIUS_POINTS) ? 64 : MAX_RADIUS_POINTS;
  localparam int NA_RESET = (64 < MAX_ANGLE_POINTS) ? 64 : MAX_ANGLE_POINTS;

  logic [NRW-1:0] nr_r, nr_nxt;
  logic [NAW-1:0] na_r, na_nxt;
  logic [15:0]    tol_r, tol_nxt;
  logic [6:0]     cfg_cnt;
  logic           cfg_xfer;
  bip_cmd_t       cmd;
  bip_stat_t      stat;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_cnt   = cfg_data[6:0];

  // saturate point counts into 2..max
  always_comb begin
    nr_nxt  = nr_r;
    na_nxt  = na_r;
    tol_nxt = tol_r;
    if (cfg_xfer) begin
      case (cfg_index)
        CFG_RADIUS_POINTS: begin
          if (cfg_cnt < 7'd2) begin
            nr_nxt = NRW'(2);
          end else if (int'(cfg_cnt) > MAX_RADIUS_POINTS) begin
            nr_nxt = NRW'(MAX_RADIUS_POINTS);
          end else begin
            nr_nxt = NRW'(cfg_cnt);
          end
        end
        CFG_ANGLE_POINTS: begin
          if (cfg_cnt < 7'd2) begin
            na_nxt = NAW'(2);
          end else if (int'(cfg_cnt) > MAX_ANGLE_POINTS) begin
            na_nxt = NAW'(MAX_ANGLE_POINTS);
          end else begin
            na_nxt = NAW'(cfg_cnt);
          end
        end
        CFG_RANGE_TOL: begin
          tol_nxt = cfg_data;
        end
        default: begin
          tol_nxt = tol_r;   // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_r  <= NRW'(NR_RESET);
      na_r  <= NAW'(NA_RESET);
      tol_r <= '0;
    end else begin
      nr_r  <= nr_nxt;
      na_r  <= na_nxt;
      tol_r <= tol_nxt;
    end
  end

  bip_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bip_dp #(
    .MAX_RADIUS_POINTS (MAX_RADIUS_POINTS),
    .MAX_ANGLE_POINTS  (MAX_ANGLE_POINTS),
    .COMPONENTS        (COMPONENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_component     (in_component),
    .in_load_data     (in_load_data),
    .in_coord_radius  (in_coord_radius),
    .in_coord_angle   (in_coord_angle),
    .radius_points    (nr_r),
    .angle_points     (na_r),
    .range_tolerance  (tol_r),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_interp_value (out_interp_value),
    .out_status       (out_status)
  );

  // a result only follows work in progress, and frees the block
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe without an item in work");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted item did not enter work");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_interp_value == '0)
    else $error("failed query returned a nonzero value");

endmodule

FILE: tb/bip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bip_checker
// Watches the item, result and register channels of the polar-grid
// interpolator, keeps its own copy of the tables and registers, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bip_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_op,
  input  logic [11:0]        in_entry_index,
  input  logic [1:0]         in_component,
  input  logic signed [31:0] in_load_data,
  input  logic signed [31:0] in_coord_radius,
  input  logic signed [31:0] in_coord_angle,
  input  logic               out_valid,
  input  logic signed [31:0] out_interp_value,
  input  logic [1:0]         out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import bip_pkg::*;

  localparam int NR = MAX_RADIUS_POINTS_DEF;
  localparam int NA = MAX_ANGLE_POINTS_DEF;
  localparam int NC = COMPONENTS_DEF;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } interp_result_t;

  logic signed [31:0] radius_bp [NR];
  logic signed [31:0] angle_bp [NA];
  logic signed [31:0] grid_mem [NR*NA*NC];
  int unsigned        n_radius;
  int unsigned        n_angle;
  logic [15:0]        tol_q;

  interp_result_t     exp_results[$];

  assign pending = exp_results.size();

  function automatic int unsigned sat_count(logic [15:0] v, int unsigned hi);
    int unsigned c;
    c = v[6:0];
    if (c < 2) return 2;
    if (c > hi) return hi;
    return c;
  endfunction

  // lower-bound search, index then forced into 1..n-1
  function automatic int unsigned find_cell(bit on_angle, int unsigned n, longint x);
    int unsigned first;
    int unsigned count;
    int unsigned step;
    int unsigned it;
    longint      e;
    first = 0;
    count = n;
    while (count > 0) begin
      step = count / 2;
      it = first + step;
      e = on_angle ? longint'(angle_bp[it]) : longint'(radius_bp[it]);
      if (e < x) begin
        first = it + 1;
        count -= step + 1;
      end else begin
        count = step;
      end
    end
    if (first >= n) first = n - 1;
    if (first == 0) first = 1;
    return first;
  endfunction

  function automatic longint weight_q16(longint x, longint lo, longint d);
    longint num;
    num = x - lo;
    if (num <= 0) return 0;
    if (num >= d) return 65536;
    return longint'((longint'(unsigned'(num)) * 65536) / d);
  endfunction

  function automatic longint node_val(int unsigned ir, int unsigned ia, int unsigned c);
    return longint'(grid_mem[(ir * n_angle + ia) * NC + c]);
  endfunction

  function automatic interp_result_t interp_predict(logic [1:0] op, logic [11:0] idx,
                                                    logic [1:0] comp, logic signed [31:0] data,
                                                    logic signed [31:0] cr,
                                                    logic signed [31:0] ca);
    interp_result_t res;
    longint r, a, rlast, tol, rlo, alo, dr, da, wr, wa, a0, a1, sum;
    int unsigned ir, ia;
    bit ok;
    res.value = '0;
    res.status = ST_OK;
    case (op)
      OP_LOAD_RADIUS: if (idx < NR) radius_bp[idx] = data;
      OP_LOAD_ANGLE:  if (idx < NA) angle_bp[idx] = data;
      OP_LOAD_GRID:   if (idx < NR*NA && comp < NC) grid_mem[idx*NC + comp] = data;
      default: begin
        tol = longint'(tol_q);
        r = cr;
        a = ca;
        rlast = radius_bp[n_radius-1];
        if (r > rlast) r = rlast;
        ok = comp < NC && r >= longint'(radius_bp[0]) - tol && r <= rlast + tol &&
             a >= longint'(angle_bp[0]) - tol && a <= longint'(angle_bp[n_angle-1]) + tol;
        if (!ok) begin
          res.status = ST_RANGE;
        end else begin
          ir = find_cell(1'b0, n_radius, r);
          ia = find_cell(1'b1, n_angle, a);
          rlo = radius_bp[ir-1];
          alo = angle_bp[ia-1];
          dr = longint'(radius_bp[ir]) - rlo;
          da = longint'(angle_bp[ia]) - alo;
          if (dr <= 0 || da <= 0) begin
            res.status = ST_ZERO_WIDTH;
          end else begin
            wr = weight_q16(r, rlo, dr);
            wa = weight_q16(a, alo, da);
            a0 = node_val(ir-1, ia-1, comp) * (65536 - wa) + node_val(ir-1, ia, comp) * wa;
            a1 = node_val(ir, ia-1, comp) * (65536 - wa) + node_val(ir, ia, comp) * wa;
            sum = a0 * (65536 - wr) + a1 * wr;
            // round half up from Q16.48
            res.value = 32'((sum + (64'sd1 <<< 31)) >>> 32);
          end
        end
      end
    endcase
    return res;
  endfunction

  interp_result_t got;
  interp_result_t want;
  int             nerr;

  always @(posedge clk) begin
    if (!rst_n) begin
      n_radius <= NR;
      n_angle <= NA;
      tol_q <= '0;
      exp_results.delete();
      errors <= 0;
    end else begin
      nerr = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIUS_POINTS: n_radius <= sat_count(cfg_data, NR);
          CFG_ANGLE_POINTS:  n_angle <= sat_count(cfg_data, NA);
          CFG_RANGE_TOL:     tol_q <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        got.value = out_interp_value;
        got.status = out_status;
        if (exp_results.size() == 0) begin
          $error("unexpected result value=%0d status=%0d", got.value, got.status);
          nerr = nerr + 1;
        end else begin
          want = exp_results.pop_front();
          if (got.value !== want.value) begin
            $error("interp_value expected %0d got %0d", want.value, got.value);
            nerr = nerr + 1;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            nerr = nerr + 1;
          end
        end
      end
      errors <= errors + nerr;
      // push after the pop so a same-cycle result never matches its own item
      if (start && !busy)
        exp_results.push_back(interp_predict(in_op, in_entry_index, in_component,
                                             in_load_data, in_coord_radius, in_coord_angle));
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the polar-grid interpolator: fills both tables
// and the grid nodes in use, runs directed corner queries, then random
// phases under several register settings and idle rates, with the checker
// alongside.
// ----------------------------------------------------------------------------
module tb_top;
  import bip_pkg::*;

  localparam int NR = MAX_RADIUS_POINTS_DEF;
  localparam int NA = MAX_ANGLE_POINTS_DEF;
  localparam int NC = COMPONENTS_DEF;

  // grid nodes loaded up front; point counts keep radius*angle within them
  localparam int GRID_R     = 12;
  localparam int GRID_A     = 12;
  localparam int GRID_NODES = GRID_R * GRID_A;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_op = '0;
  logic [11:0]        in_entry_index = '0;
  logic [1:0]         in_component = '0;
  logic signed [31:0] in_load_data = '0;
  logic signed [31:0] in_coord_radius = '0;
  logic signed [31:0] in_coord_angle = '0;
  logic               out_valid;
  logic signed [31:0] out_interp_value;
  logic [1:0]         out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 errors;
  int                 pending;

  // stimulus-side view of the tables, used to aim queries
  logic signed [31:0] radius_view [NR];
  logic signed [31:0] angle_view [NA];
  int unsigned        use_r = NR;
  int unsigned        use_a = NA;
  int unsigned        tol_view = 0;
  int unsigned        idle_pct = 0;

  bilinear_interp_polar_grid u_top (.*);

  bip_checker u_chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("bilinear_interp_polar_grid verification failed");
    $finish;
  end

  task automatic send(logic [1:0] op, logic [11:0] idx, logic [1:0] comp,
                      logic signed [31:0] data, logic signed [31:0] r,
                      logic signed [31:0] a);
    start <= 1'b1;
    in_op <= op;
    in_entry_index <= idx;
    in_component <= comp;
    in_load_data <= data;
    in_coord_radius <= r;
    in_coord_angle <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_LOAD_RADIUS && idx < NR) radius_view[idx] = data;
    if (op == OP_LOAD_ANGLE && idx < NA) angle_view[idx] = data;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (index == CFG_RADIUS_POINTS)
      use_r = data[6:0] < 2 ? 2 : (data[6:0] > NR ? NR : data[6:0]);
    if (index == CFG_ANGLE_POINTS)
      use_a = data[6:0] < 2 ? 2 : (data[6:0] > NA ? NA : data[6:0]);
    if (index == CFG_RANGE_TOL) tol_view = data;
  endtask

  // sorted tables; with dups set, some steps are zero or negative
  task automatic load_axes(bit dups);
    int signed rv;
    int signed av;
    rv = $urandom_range(2000000) - 1000000;
    av = $urandom_range(2000000) - 1000000;
    for (int i = 0; i < NR; i++) begin
      send(OP_LOAD_RADIUS, 12'(i), '0, rv, '0, '0);
      rv += (dups && $urandom_range(3) == 0) ? -int'($urandom_range(1)) * 7
                                             : int'($urandom_range(200000, 1));
    end
    for (int i = 0; i < NA; i++) begin
      send(OP_LOAD_ANGLE, 12'(i), '0, av, '0, '0);
      av += (dups && $urandom_range(3) == 0) ? -int'($urandom_range(1)) * 7
                                             : int'($urandom_range(200000, 1));
    end
  endtask

  function automatic logic signed [31:0] aim(bit on_angle);
    longint lo;
    longint hi;
    lo = (on_angle ? angle_view[0] : radius_view[0]) - longint'(tol_view) - 50;
    hi = (on_angle ? angle_view[use_a-1] : radius_view[use_r-1]) + longint'(tol_view) + 50;
    if (hi <= lo) hi = lo + 100;
    return 32'(lo + longint'($urandom_range(32'(hi - lo))));
  endfunction

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send(OP_QUERY, 12'($urandom), $urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2)),
           $urandom, aim(1'b0), aim(1'b1));
    else if (pick < 63)
      send(OP_QUERY, 12'($urandom), 2'($urandom), $urandom, $urandom, $urandom);
    else if (pick < 80)
      send(OP_LOAD_GRID, 12'($urandom), 2'($urandom_range(2)), $urandom, $urandom, $urandom);
    else if (pick < 86)
      send(2'($urandom_range(1)), 12'($urandom_range(NR-1)), 2'($urandom),
           $urandom_range(1) ? aim(1'b0) : $urandom, $urandom, $urandom);
    else
      send(2'($urandom_range(2)), 12'($urandom_range(4095, NR)), 2'($urandom),
           $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_axes(1'b0);
    for (int n = 0; n < GRID_NODES; n++)
      for (int c = 0; c < NC; c++)
        send(OP_LOAD_GRID, 12'(n), 2'(c), $urandom, '0, '0);
    write_reg(CFG_RADIUS_POINTS, 16'(GRID_R));
    write_reg(CFG_ANGLE_POINTS, 16'(GRID_A));

    // corners: extreme grid data, table edges, clamp, slack, bad component
    send(OP_LOAD_GRID, 12'd0, 2'd0, 32'sh7fffffff, '0, '0);
    send(OP_LOAD_GRID, 12'd1, 2'd0, 32'sh80000000, '0, '0);
    send(OP_LOAD_GRID, 12'(GRID_A), 2'd0, 32'sh80000000, '0, '0);
    send(OP_LOAD_GRID, 12'(GRID_A+1), 2'd0, 32'sh7fffffff, '0, '0);
    send(OP_LOAD_GRID, 12'd4095, 2'd3, 32'sh5555aaaa, '0, '0);
    send(OP_LOAD_RADIUS, 12'd64, '0, 32'sh7fffffff, '0, '0);
    send(OP_LOAD_ANGLE, 12'd4095, '0, 32'sh80000000, '0, '0);
    send(OP_QUERY, '0, 2'd0, '0, radius_view[0], angle_view[0]);
    send(OP_QUERY, '0, 2'd0, '0, radius_view[1], angle_view[1]);
    send(OP_QUERY, '0, 2'd0, '0, (radius_view[0] + radius_view[1]) / 2,
         (angle_view[0] + angle_view[1]) / 2);
    send(OP_QUERY, '0, 2'd1, '0, radius_view[GRID_R-1], angle_view[GRID_A-1]);
    send(OP_QUERY, '0, 2'd2, '0, 32'sh7fffffff, angle_view[5]);
    send(OP_QUERY, '0, 2'd2, '0, radius_view[0] - 1, angle_view[5]);
    send(OP_QUERY, '0, 2'd2, '0, radius_view[3], angle_view[GRID_A-1] + 1);
    send(OP_QUERY, '0, 2'd2, '0, radius_view[3], angle_view[0] - 1);
    send(OP_QUERY, '0, 2'd3, '0, radius_view[3], angle_view[3]);
    send(OP_QUERY, '0, 2'd0, '0, 32'sh80000000, 32'sh80000000);
    write_reg(CFG_RANGE_TOL, 16'hffff);
    send(OP_QUERY, '0, 2'd0, '0, radius_view[0] - 65535, angle_view[0] - 65535);
    send(OP_QUERY, '0, 2'd0, '0, radius_view[0] - 65536, angle_view[0]);
    send(OP_QUERY, '0, 2'd1, '0, radius_view[4], angle_view[GRID_A-1] + 65535);
    send(OP_QUERY, '0, 2'd1, '0, radius_view[4], angle_view[GRID_A-1] + 65536);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin write_reg(CFG_RADIUS_POINTS, 16'(GRID_R));
                 write_reg(CFG_ANGLE_POINTS, 16'(GRID_A));
                 write_reg(CFG_RANGE_TOL, 16'd0); end
        1: begin write_reg(CFG_RADIUS_POINTS, 16'd0); write_reg(CFG_ANGLE_POINTS, 16'd127); end
        2: begin write_reg(CFG_RADIUS_POINTS, 16'hffff); write_reg(CFG_ANGLE_POINTS, 16'd2);
                 write_reg(CFG_RANGE_TOL, 16'(65535)); end
        3: begin write_reg(CFG_RADIUS_POINTS, 16'(5)); write_reg(CFG_ANGLE_POINTS, 16'd9);
                 write_reg(2'd3, 16'($urandom)); end
        4: load_axes(1'b1);
        6: load_axes(1'b0);
        default: begin
          write_reg(CFG_RADIUS_POINTS, {9'($urandom), 7'($urandom_range(GRID_R))});
          write_reg(CFG_ANGLE_POINTS, {9'($urandom), 7'($urandom_range(GRID_A))});
          write_reg(CFG_RANGE_TOL, 16'($urandom));
        end
      endcase
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 87;
        2: idle_pct = 19;
        default: idle_pct = 87;
      endcase
      for (int k = 0; k < 85; k++) random_item();
    end

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("bilinear_interp_polar_grid verification clean");
    end else begin
      $display("bilinear_interp_polar_grid verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bip_pkg.sv
hw/rtl/bip_ram.sv
hw/rtl/bip_div.sv
hw/rtl/bip_dp.sv
hw/rtl/bip_ctrl.sv
hw/rtl/bilinear_interp_polar_grid.sv
tb/bip_checker.sv
tb/tb_top.sv
